/* rtl/brc_pkg.sv */
// Package for the barrier release controller: sizes, codes, the slot record
// and the mask helpers. No dependencies.
`default_nettype none

package brc_pkg;

  localparam int unsigned MEMBERS  = 32;
  localparam int unsigned BARRIERS = 16;

  localparam int unsigned IDX_W = (BARRIERS > 1) ? $clog2(BARRIERS) : 1;
  localparam int unsigned CNT_W = $clog2(MEMBERS + 1);
  localparam int unsigned REQ_W = CNT_W + 7;
  localparam int unsigned PRD_W = CNT_W + 18;

  typedef logic [MEMBERS-1:0] mask_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [IDX_W-1:0]   idx_t;

  typedef enum logic [1:0] {
    MODE_CREATE  = 2'd0,
    MODE_ARRIVE  = 2'd1,
    MODE_FAIL    = 2'd2,
    MODE_TIMEOUT = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_WAITING  = 2'd0,
    ST_RELEASED = 2'd1,
    ST_FAILED   = 2'd2,
    ST_TIMEDOUT = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    RSN_CREATED      = 4'd0,
    RSN_UNKNOWN      = 4'd1,
    RSN_ALREADY_REL  = 4'd2,
    RSN_FAIL_BARRIER = 4'd3,
    RSN_FAIL_EARLY   = 4'd4,
    RSN_ARRIVAL_REL  = 4'd5,
    RSN_WAITING      = 4'd6,
    RSN_TMO_ARRIVED  = 4'd7,
    RSN_TMO_QUORUM   = 4'd8,
    RSN_TIMEOUT      = 4'd9
  } reason_e;

  localparam logic [1:0] ARR_ALL        = 2'd0;
  localparam logic [1:0] ARR_COUNT_FAIL = 2'd1;
  localparam logic [1:0] ARR_DROP_FAIL  = 2'd2;
  localparam logic [1:0] ARR_QUORUM     = 2'd3;

  localparam logic [1:0] FLR_FAIL_BARRIER = 2'd0;
  localparam logic [1:0] FLR_REMOVE       = 2'd1;

  localparam logic [2:0] TMO_REL_ARRIVED = 3'd0;
  localparam logic [2:0] TMO_REL_QUORUM  = 3'd1;

  localparam logic [1:0] OUT_PASSED = 2'd0;
  localparam logic [1:0] OUT_FAILED = 2'd1;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_e;

  typedef struct packed {
    status_e     status;
    mask_t       expected;
    mask_t       arrived;
    mask_t       failed;
    mask_t       dropped;
    mask_t       released;
    logic [1:0]  arr_rule;
    logic [1:0]  fail_rule;
    logic [2:0]  tmo_rule;
    logic [5:0]  qfix;
    logic [16:0] ratio;
  } rec_t;

  function automatic cnt_t popcnt(input mask_t m);
    cnt_t n;
    n = '0;
    for (int i = 0; i < int'(MEMBERS); i++) begin
      n = n + cnt_t'(m[i]);
    end
    return n;
  endfunction

  function automatic mask_t mask_from_word(input logic [31:0] w);
    mask_t m;
    m = '0;
    for (int i = 0; i < int'(MEMBERS); i++) begin
      if (i < 32) m[i] = w[i];
    end
    return m;
  endfunction

  function automatic logic [31:0] mask_to_word(input mask_t m);
    logic [31:0] w;
    w = '0;
    for (int i = 0; i < 32; i++) begin
      if (i < int'(MEMBERS)) w[i] = m[i];
    end
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/barrier_release_controller_top.sv */
// Barrier release controller: slot table in one synchronous memory with a
// read-modify-write sequencer. Depends on brc_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one operation per beat:
//   create, member arrived, member failed before arrival, or timeout.
//   Output channel (out_valid_o / out_ready_i) returns exactly one result
//   beat per input beat, in order.
// Sequencing:
//   An accepted beat reads its slot record from the table memory at the
//   accept edge; the compute state then computes the update, writes the
//   record back and loads the result register, which drives out_valid_o.
//   The single memory read-modify-write means in_ready_o stays low until
//   the beat leaves the compute state, which waits while the output
//   register is still occupied.
//   Because each write-back lands before the next read is issued, back to
//   back beats to the same slot always see the updated record.
// Reset:
//   Clears the slot valid bits, the allocation counter, the sequencer and
//   the output valid. The table memory is not cleared: a slot's record is
//   only used after a create has written it.
// Stall:
//   A waiting result holds in the output register; the next beat is still
//   accepted and read, then holds in the compute cycle until the output
//   register frees up.
`default_nettype none

module barrier_release_controller_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [3:0]  barrier_slot_i,
  input  wire logic [4:0]  member_i,
  input  wire logic [1:0]  outcome_i,
  input  wire logic [31:0] expected_in_i,
  input  wire logic [1:0]  arrival_rule_i,
  input  wire logic [1:0]  failure_rule_i,
  input  wire logic [2:0]  timeout_rule_i,
  input  wire logic [5:0]  quorum_fixed_i,
  input  wire logic [16:0] quorum_ratio_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       slot_out_o,
  output logic [1:0]       status_o,
  output logic [31:0]      released_set_o,
  output logic [31:0]      dropped_set_o,
  output logic [3:0]       reason_code_o
);

  // Sequencer and bookkeeping
  brc_pkg::fsm_e  state_q, state_d;
  brc_pkg::idx_t  next_slot_q, next_slot_d;
  logic [brc_pkg::BARRIERS-1:0] slot_valid_q, slot_valid_d;

  logic in_accept;
  logic advance;

  // Captured request
  logic [1:0]  req_mode_q;
  logic [3:0]  req_slot_q;
  logic [4:0]  req_member_q;
  logic [1:0]  req_outcome_q;
  logic [31:0] req_expected_q;
  logic [1:0]  req_arr_q;
  logic [1:0]  req_fail_q;
  logic [2:0]  req_tmo_q;
  logic [5:0]  req_qfix_q;
  logic [16:0] req_ratio_q;

  // Table memory
  brc_pkg::rec_t mem_q [brc_pkg::BARRIERS];
  brc_pkg::rec_t rd_q;
  brc_pkg::rec_t wr_rec;
  brc_pkg::idx_t wr_idx;
  logic          wr_en;

  // Output register
  logic        out_valid_q;
  logic [3:0]  out_slot_q, out_slot_d;
  logic [1:0]  out_status_q, out_status_d;
  logic [31:0] out_rel_q, out_rel_d;
  logic [31:0] out_drp_q, out_drp_d;
  logic [3:0]  out_reason_q, out_reason_d;

  // Compute-cycle signals
  brc_pkg::idx_t  req_idx;
  logic           slot_known;
  brc_pkg::mask_t member_bit;
  brc_pkg::rec_t  upd;
  brc_pkg::cnt_t  n_exp, n_drp, n_arr;
  logic [brc_pkg::PRD_W-1:0] q_sum;
  logic [brc_pkg::REQ_W-1:0] q_ceil, req_cnt;
  logic           enough;

  assign in_accept = in_valid_i && in_ready_o;
  assign advance   = (state_q == brc_pkg::FSM_EXEC) && (!out_valid_q || out_ready_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      brc_pkg::FSM_IDLE: if (in_valid_i) state_d = brc_pkg::FSM_EXEC;
      brc_pkg::FSM_EXEC: if (advance) state_d = brc_pkg::FSM_IDLE;
      default:           state_d = brc_pkg::FSM_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready_o = 1'b0;
    case (state_q)
      brc_pkg::FSM_IDLE: in_ready_o = 1'b1;
      brc_pkg::FSM_EXEC: in_ready_o = 1'b0;
      default:           in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= brc_pkg::FSM_IDLE;
      next_slot_q  <= '0;
      slot_valid_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      next_slot_q  <= next_slot_d;
      slot_valid_q <= slot_valid_d;
      if (advance)          out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Capture the request at the accept edge
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_mode_q     <= mode_i;
      req_slot_q     <= barrier_slot_i;
      req_member_q   <= member_i;
      req_outcome_q  <= outcome_i;
      req_expected_q <= expected_in_i;
      req_arr_q      <= arrival_rule_i;
      req_fail_q     <= failure_rule_i;
      req_tmo_q      <= timeout_rule_i;
      req_qfix_q     <= quorum_fixed_i;
      req_ratio_q    <= quorum_ratio_i;
    end
  end

  // Memory: read at accept, write back when the compute cycle advances
  always_ff @(posedge clk_i) begin
    if (in_accept) rd_q <= mem_q[brc_pkg::idx_t'(barrier_slot_i)];
    if (wr_en) mem_q[wr_idx] <= wr_rec;
  end

  assign req_idx    = brc_pkg::idx_t'(req_slot_q);
  assign slot_known = (32'(req_slot_q) < 32'(brc_pkg::BARRIERS)) && slot_valid_q[req_idx];
  assign member_bit = (32'(req_member_q) < 32'(brc_pkg::MEMBERS))
                    ? (brc_pkg::mask_t'(1) << req_member_q) : '0;

  // Apply the mask updates of the operation to the fetched record
  always_comb begin
    upd = rd_q;
    case (brc_pkg::mode_e'(req_mode_q))
      brc_pkg::MODE_ARRIVE: begin
        if (req_outcome_q == brc_pkg::OUT_PASSED) begin
          upd.arrived = rd_q.arrived | member_bit;
        end else begin
          upd.failed = rd_q.failed | member_bit;
          if (rd_q.arr_rule == brc_pkg::ARR_COUNT_FAIL) upd.arrived = rd_q.arrived | member_bit;
          if (rd_q.arr_rule == brc_pkg::ARR_DROP_FAIL || rd_q.fail_rule == brc_pkg::FLR_REMOVE)
            upd.dropped = rd_q.dropped | member_bit;
        end
      end
      brc_pkg::MODE_FAIL: begin
        upd.failed = rd_q.failed | member_bit;
        if (req_outcome_q == brc_pkg::OUT_FAILED &&
            (rd_q.fail_rule == brc_pkg::FLR_REMOVE || rd_q.arr_rule == brc_pkg::ARR_DROP_FAIL))
          upd.dropped = rd_q.dropped | member_bit;
      end
      default: ;
    endcase
  end

  // Required count on the updated record
  assign n_exp  = brc_pkg::popcnt(upd.expected);
  assign n_drp  = brc_pkg::popcnt(upd.dropped);
  assign n_arr  = brc_pkg::popcnt(upd.arrived);
  assign q_sum  = brc_pkg::PRD_W'(n_exp) * brc_pkg::PRD_W'(upd.ratio)
                + brc_pkg::PRD_W'(17'd65535);
  assign q_ceil = brc_pkg::REQ_W'(q_sum >> 16);

  always_comb begin
    if (upd.arr_rule == brc_pkg::ARR_QUORUM) begin
      if (upd.qfix != '0)       req_cnt = brc_pkg::REQ_W'(upd.qfix);
      else if (q_ceil == '0)    req_cnt = brc_pkg::REQ_W'(1);
      else                      req_cnt = q_ceil;
    end else begin
      req_cnt = (n_exp > n_drp) ? brc_pkg::REQ_W'(n_exp - n_drp) : '0;
    end
  end

  assign enough = brc_pkg::REQ_W'(n_arr) >= req_cnt;

  // Decide the result and the record to write back
  always_comb begin
    logic              do_eval;
    brc_pkg::reason_e  rel_reason;
    do_eval      = 1'b0;
    rel_reason   = brc_pkg::RSN_ARRIVAL_REL;
    wr_rec       = upd;
    wr_idx       = req_idx;
    wr_en        = 1'b0;
    next_slot_d  = next_slot_q;
    slot_valid_d = slot_valid_q;
    out_slot_d   = req_slot_q;
    out_status_d = brc_pkg::ST_FAILED;
    out_rel_d    = '0;
    out_drp_d    = '0;
    out_reason_d = brc_pkg::RSN_UNKNOWN;

    if (brc_pkg::mode_e'(req_mode_q) == brc_pkg::MODE_CREATE) begin
      wr_idx          = next_slot_q;
      wr_rec.status   = brc_pkg::ST_WAITING;
      wr_rec.expected = brc_pkg::mask_from_word(req_expected_q);
      wr_rec.arrived  = '0;
      wr_rec.failed   = '0;
      wr_rec.dropped  = '0;
      wr_rec.released = '0;
      wr_rec.arr_rule = req_arr_q;
      wr_rec.fail_rule = req_fail_q;
      wr_rec.tmo_rule = req_tmo_q;
      wr_rec.qfix     = req_qfix_q;
      wr_rec.ratio    = req_ratio_q;
      wr_en           = advance;
      if (advance) begin
        slot_valid_d[next_slot_q] = 1'b1;
        next_slot_d = (32'(next_slot_q) == 32'(brc_pkg::BARRIERS - 1))
                    ? '0 : next_slot_q + brc_pkg::idx_t'(1);
      end
      out_slot_d   = 4'(next_slot_q);
      out_status_d = brc_pkg::ST_WAITING;
      out_reason_d = brc_pkg::RSN_CREATED;
    end else if (slot_known) begin
      wr_en     = advance;
      out_drp_d = brc_pkg::mask_to_word(upd.dropped);
      case (brc_pkg::mode_e'(req_mode_q))
        brc_pkg::MODE_ARRIVE: begin
          do_eval    = 1'b1;
          rel_reason = brc_pkg::RSN_ARRIVAL_REL;
        end
        brc_pkg::MODE_FAIL: begin
          if (upd.fail_rule == brc_pkg::FLR_FAIL_BARRIER) begin
            wr_rec.status = brc_pkg::ST_FAILED;
            out_status_d  = brc_pkg::ST_FAILED;
            out_drp_d     = '0;
            out_reason_d  = brc_pkg::RSN_FAIL_EARLY;
          end else begin
            do_eval    = 1'b1;
            rel_reason = brc_pkg::RSN_FAIL_EARLY;
          end
        end
        default: begin
          if (upd.tmo_rule == brc_pkg::TMO_REL_ARRIVED) begin
            wr_rec.released = upd.arrived;
            wr_rec.status   = brc_pkg::ST_RELEASED;
            out_status_d    = brc_pkg::ST_RELEASED;
            out_rel_d       = brc_pkg::mask_to_word(upd.arrived);
            out_reason_d    = brc_pkg::RSN_TMO_ARRIVED;
          end else if (upd.tmo_rule == brc_pkg::TMO_REL_QUORUM) begin
            do_eval    = 1'b1;
            rel_reason = brc_pkg::RSN_TMO_QUORUM;
          end else begin
            wr_rec.status = brc_pkg::ST_TIMEDOUT;
            out_status_d  = brc_pkg::ST_TIMEDOUT;
            out_reason_d  = brc_pkg::RSN_TIMEOUT;
          end
        end
      endcase

      // Release evaluation
      if (do_eval) begin
        if (upd.status == brc_pkg::ST_RELEASED) begin
          out_status_d = brc_pkg::ST_RELEASED;
          out_rel_d    = brc_pkg::mask_to_word(upd.released);
          out_reason_d = brc_pkg::RSN_ALREADY_REL;
        end else if (upd.fail_rule == brc_pkg::FLR_FAIL_BARRIER && upd.failed != '0) begin
          wr_rec.status = brc_pkg::ST_FAILED;
          out_status_d  = brc_pkg::ST_FAILED;
          out_reason_d  = brc_pkg::RSN_FAIL_BARRIER;
        end else if (enough) begin
          wr_rec.released = upd.arrived;
          wr_rec.status   = brc_pkg::ST_RELEASED;
          out_status_d    = brc_pkg::ST_RELEASED;
          out_rel_d       = brc_pkg::mask_to_word(upd.arrived);
          out_reason_d    = rel_reason;
        end else begin
          out_status_d = brc_pkg::ST_WAITING;
          out_reason_d = brc_pkg::RSN_WAITING;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_slot_q   <= out_slot_d;
      out_status_q <= out_status_d;
      out_rel_q    <= out_rel_d;
      out_drp_q    <= out_drp_d;
      out_reason_q <= out_reason_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign slot_out_o     = out_slot_q;
  assign status_o       = out_status_q;
  assign released_set_o = out_rel_q;
  assign dropped_set_o  = out_drp_q;
  assign reason_code_o  = out_reason_q;

  // Checks
  a_accept_starts_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == brc_pkg::FSM_EXEC))
    else $error("accepted beat did not start the compute cycle");

  a_advance_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("compute cycle finished without a result");

  a_write_only_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == brc_pkg::FSM_EXEC) && advance)
    else $error("table written outside a finishing compute cycle");

  a_valid_never_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((slot_valid_q & $past(slot_valid_q)) == $past(slot_valid_q)))
    else $error("slot valid bit cleared");

  a_next_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(next_slot_q) < 32'(brc_pkg::BARRIERS))
    else $error("allocation counter out of range");

endmodule

`default_nettype wire

/* bench/barrier_release_controller_top_test.sv */
// Self-checking bench for barrier_release_controller_top: drives operation beats, predicts each
// result from a behavioral copy of the slot table and compares every result beat field by field.
// Depends on brc_pkg and the block itself.
module barrier_release_controller_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import brc_pkg::*;

  // Outcome, failure and timeout codes the package leaves unnamed.
  localparam logic [1:0] OUT_OTHER       = 2'd2;
  localparam logic [1:0] OUT_OTHER_HI    = 2'd3;
  localparam logic [1:0] FLR_CONTINUE    = 2'd2;
  localparam logic [1:0] FLR_UNLISTED    = 2'd3;
  localparam logic [2:0] TMO_EXPIRE      = 3'd2;
  localparam logic [2:0] TMO_UNLISTED_LO = 3'd5;
  localparam logic [2:0] TMO_UNLISTED_HI = 3'd7;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned RANDOM_BEATS = 1425;
  localparam int unsigned GAP_LONGEST  = 40;   // longest sender gap
  localparam int unsigned HOLD_LONGEST = 60;   // longest receiver stall
  localparam int unsigned DRAIN_CYCLES = 16;   // idle wait after the last result
  localparam int unsigned QUIET_LIMIT  = 4000; // cycles without any beat moving

  typedef struct {
    mode_e       mode;
    logic [3:0]  slot;
    logic [4:0]  member;
    logic [1:0]  outcome;
    logic [31:0] members;
    logic [1:0]  arr_rule;
    logic [1:0]  flr_rule;
    logic [2:0]  tmo_rule;
    logic [5:0]  qfix;
    logic [16:0] ratio;
  } barrier_event_t;

  typedef struct {
    logic [3:0]  slot;
    status_e     status;
    logic [31:0] released;
    logic [31:0] dropped;
    reason_e     reason;
  } verdict_t;

  typedef struct {
    logic [1:0]  arr_rule;
    logic [1:0]  flr_rule;
    logic [2:0]  tmo_rule;
    logic [5:0]  qfix;
    logic [16:0] ratio;
  } slot_policy_t;

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i         = MODE_CREATE;
  logic [3:0]  barrier_slot_i = '0;
  logic [4:0]  member_i       = '0;
  logic [1:0]  outcome_i      = OUT_PASSED;
  logic [31:0] expected_in_i  = '0;
  logic [1:0]  arrival_rule_i = ARR_ALL;
  logic [1:0]  failure_rule_i = FLR_FAIL_BARRIER;
  logic [2:0]  timeout_rule_i = TMO_REL_ARRIVED;
  logic [5:0]  quorum_fixed_i = '0;
  logic [16:0] quorum_ratio_i = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [3:0]  slot_out_o;
  logic [1:0]  status_o;
  logic [31:0] released_set_o;
  logic [31:0] dropped_set_o;
  logic [3:0]  reason_code_o;

  barrier_release_controller_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .barrier_slot_i (barrier_slot_i),
    .member_i       (member_i),
    .outcome_i      (outcome_i),
    .expected_in_i  (expected_in_i),
    .arrival_rule_i (arrival_rule_i),
    .failure_rule_i (failure_rule_i),
    .timeout_rule_i (timeout_rule_i),
    .quorum_fixed_i (quorum_fixed_i),
    .quorum_ratio_i (quorum_ratio_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .slot_out_o     (slot_out_o),
    .status_o       (status_o),
    .released_set_o (released_set_o),
    .dropped_set_o  (dropped_set_o),
    .reason_code_o  (reason_code_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow slot table. Only entries marked live are ever consulted, matching
  // the block, whose table memory is not cleared by reset.
  // ---------------------------------------------------------------------------
  logic         slot_live [SLOTS] = '{default: 1'b0};
  status_e      slot_state[SLOTS];
  logic [31:0]  exp_m     [SLOTS];
  logic [31:0]  arr_m     [SLOTS];
  logic [31:0]  fail_m    [SLOTS];
  logic [31:0]  drop_m    [SLOTS];
  logic [31:0]  rel_m     [SLOTS];
  slot_policy_t policy    [SLOTS];
  logic [3:0]   alloc_ptr = '0;

  verdict_t     pending_verdicts[$];

  int unsigned  mismatches     = 0;
  int unsigned  beats_in       = 0;
  int unsigned  creates_seen   = 0;
  int unsigned  results_seen   = 0;
  int unsigned  releases_seen  = 0;
  int unsigned  failures_seen  = 0;
  int unsigned  timeouts_seen  = 0;
  bit           calm           = 1'b0; // suppress gaps and stalls on both sides

  // Members needed for release: fixed quorum, rounded-up ratio quorum, or
  // expected minus dropped (floored at zero) for the non-quorum rules.
  function automatic int unsigned quota_needed(logic [3:0] s);
    int unsigned    ne;
    int unsigned    nd;
    longint unsigned q;
    ne = $countones(exp_m[s]);
    nd = $countones(drop_m[s]);
    if (policy[s].arr_rule == ARR_QUORUM) begin
      if (policy[s].qfix != 0) return policy[s].qfix;
      q = (64'(ne) * 64'(policy[s].ratio) + 64'd65535) >> 16;
      return (q < 1) ? 1 : int'(q);
    end
    return (ne > nd) ? ne - nd : 0;
  endfunction

  // Decide whether a live slot releases; failed and timed-out slots are
  // judged exactly like waiting ones.
  function automatic verdict_t settle_slot(logic [3:0] s, reason_e why);
    verdict_t v;
    v.slot     = s;
    v.released = '0;
    v.dropped  = drop_m[s];
    if (slot_state[s] == ST_RELEASED) begin
      v.status   = ST_RELEASED;
      v.released = rel_m[s];
      v.reason   = RSN_ALREADY_REL;
    end else if (policy[s].flr_rule == FLR_FAIL_BARRIER && fail_m[s] != 0) begin
      slot_state[s] = ST_FAILED;
      v.status      = ST_FAILED;
      v.reason      = RSN_FAIL_BARRIER;
    end else if ($countones(arr_m[s]) >= quota_needed(s)) begin
      rel_m[s]      = arr_m[s];
      slot_state[s] = ST_RELEASED;
      v.status      = ST_RELEASED;
      v.released    = rel_m[s];
      v.reason      = why;
    end else begin
      v.status = ST_WAITING;
      v.reason = RSN_WAITING;
    end
    return v;
  endfunction

  // Apply one accepted beat to the shadow table and return its result.
  function automatic verdict_t predict_verdict(barrier_event_t ev);
    verdict_t    v;
    logic [31:0] bit_m;
    logic [3:0]  s;
    s          = ev.slot;
    bit_m      = 32'h1 << ev.member;
    v.slot     = s;
    v.status   = ST_WAITING;
    v.released = '0;
    v.dropped  = '0;
    v.reason   = RSN_CREATED;

    if (ev.mode == MODE_CREATE) begin
      s             = alloc_ptr;
      alloc_ptr     = alloc_ptr + 4'd1;
      creates_seen++;
      slot_live[s]  = 1'b1;
      slot_state[s] = ST_WAITING;
      exp_m[s]      = ev.members;
      arr_m[s]      = '0;
      fail_m[s]     = '0;
      drop_m[s]     = '0;
      rel_m[s]      = '0;
      policy[s]     = '{ev.arr_rule, ev.flr_rule, ev.tmo_rule, ev.qfix, ev.ratio};
      v.slot        = s;
      return v;
    end

    if (!slot_live[s]) begin
      v.status = ST_FAILED;
      v.reason = RSN_UNKNOWN;
      return v;
    end

    case (ev.mode)
      MODE_ARRIVE: begin
        if (ev.outcome == OUT_PASSED) begin
          arr_m[s] |= bit_m;
        end else begin
          fail_m[s] |= bit_m;
          if (policy[s].arr_rule == ARR_COUNT_FAIL) arr_m[s] |= bit_m;
          if (policy[s].arr_rule == ARR_DROP_FAIL || policy[s].flr_rule == FLR_REMOVE)
            drop_m[s] |= bit_m;
        end
        return settle_slot(s, RSN_ARRIVAL_REL);
      end
      MODE_FAIL: begin
        fail_m[s] |= bit_m;
        if (ev.outcome == OUT_FAILED &&
            (policy[s].flr_rule == FLR_REMOVE || policy[s].arr_rule == ARR_DROP_FAIL))
          drop_m[s] |= bit_m;
        if (policy[s].flr_rule == FLR_FAIL_BARRIER) begin
          // Early failure under the fail-barrier rule reports both sets empty.
          slot_state[s] = ST_FAILED;
          v.status      = ST_FAILED;
          v.reason      = RSN_FAIL_EARLY;
          return v;
        end
        return settle_slot(s, RSN_FAIL_EARLY);
      end
      default: begin
        if (policy[s].tmo_rule == TMO_REL_ARRIVED) begin
          // Release whoever is there, even over an earlier release.
          rel_m[s]      = arr_m[s];
          slot_state[s] = ST_RELEASED;
          v.status      = ST_RELEASED;
          v.released    = rel_m[s];
          v.dropped     = drop_m[s];
          v.reason      = RSN_TMO_ARRIVED;
        end else if (policy[s].tmo_rule == TMO_REL_QUORUM) begin
          return settle_slot(s, RSN_TMO_QUORUM);
        end else begin
          slot_state[s] = ST_TIMEDOUT;
          v.status      = ST_TIMEDOUT;
          v.dropped     = drop_m[s];
          v.reason      = RSN_TIMEOUT;
        end
      end
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat builders
  // ---------------------------------------------------------------------------

  // Fully random beat: every field at any value its width allows.
  function automatic barrier_event_t scatter_event();
    barrier_event_t ev;
    ev.mode     = mode_e'($urandom_range(3));
    ev.slot     = 4'($urandom_range(15));
    ev.member   = 5'($urandom_range(31));
    ev.outcome  = 2'($urandom_range(3));
    ev.members  = $urandom;
    ev.arr_rule = 2'($urandom_range(3));
    ev.flr_rule = 2'($urandom_range(3));
    ev.tmo_rule = 3'($urandom_range(7));
    ev.qfix     = 6'($urandom_range(63));
    ev.ratio    = 17'($urandom_range(131071));
    return ev;
  endfunction

  function automatic barrier_event_t create_event(logic [31:0] members, logic [1:0] arr,
                                                  logic [1:0] flr, logic [2:0] tmo,
                                                  logic [5:0] qfix, logic [16:0] ratio);
    barrier_event_t ev;
    ev          = scatter_event();
    ev.mode     = MODE_CREATE;
    ev.members  = members;
    ev.arr_rule = arr;
    ev.flr_rule = flr;
    ev.tmo_rule = tmo;
    ev.qfix     = qfix;
    ev.ratio    = ratio;
    return ev;
  endfunction

  // Member operations leave the create-only fields random; the block ignores them.
  function automatic barrier_event_t member_event(mode_e op, logic [3:0] s, logic [4:0] m,
                                                  logic [1:0] oc);
    barrier_event_t ev;
    ev         = scatter_event();
    ev.mode    = op;
    ev.slot    = s;
    ev.member  = m;
    ev.outcome = oc;
    return ev;
  endfunction

  function automatic logic [3:0] newest_slot();
    return alloc_ptr - 4'd1;
  endfunction

  // Favor the most recently created barriers so they live long enough to release.
  function automatic logic [3:0] pick_live_slot();
    int unsigned live;
    int unsigned back;
    live = (creates_seen > SLOTS) ? SLOTS : creates_seen;
    if ($urandom_range(99) < 70) back = $urandom_range((live < 4) ? live - 1 : 3);
    else back = $urandom_range(live - 1);
    return alloc_ptr - 4'd1 - 4'(back);
  endfunction

  function automatic barrier_event_t random_create_event();
    logic [31:0] members;
    logic [5:0]  qfix;
    logic [16:0] ratio;
    int unsigned r;
    int unsigned k;
    members = '0;
    r = $urandom_range(99);
    if (r < 50) begin
      k = $urandom_range(6, 1);
      repeat (k) members[$urandom_range(31)] = 1'b1;
    end else if (r < 70) members = $urandom;
    else if (r < 80) members = '1;
    else if (r < 90) members = '0;
    else members = 32'hFFFF_FFFF >> $urandom_range(31);

    r = $urandom_range(99);
    if (r < 60) qfix = '0;
    else if (r < 90) qfix = 6'($urandom_range(8, 1));
    else qfix = 6'($urandom_range(63));

    r = $urandom_range(99);
    if (r < 40) ratio = 17'($urandom_range(65536));
    else if (r < 70) ratio = 17'($urandom_range(4) * 16384);
    else ratio = 17'($urandom_range(131071));

    return create_event(members, 2'($urandom_range(3)), 2'($urandom_range(3)),
                        3'($urandom_range(7)), qfix, ratio);
  endfunction

  // Member traffic on a live barrier, mostly from its own expected set.
  function automatic barrier_event_t random_member_event();
    logic [3:0]  s;
    logic [4:0]  m;
    logic [1:0]  oc;
    mode_e       op;
    int unsigned r;
    int unsigned tries;
    s  = pick_live_slot();
    r  = $urandom_range(99);
    op = (r < 72) ? MODE_ARRIVE : (r < 87) ? MODE_FAIL : MODE_TIMEOUT;
    m  = 5'($urandom_range(31));
    if (exp_m[s] != 0 && $urandom_range(9) < 8) begin
      tries = 0;
      while (!exp_m[s][m] && tries < 64) begin
        m = 5'($urandom_range(31));
        tries++;
      end
    end
    oc = ($urandom_range(99) < 75) ? OUT_PASSED : 2'($urandom_range(3, 1));
    return member_event(op, s, m, oc);
  endfunction

  // Mostly no idling, some short gaps, a few long ones.
  function automatic int unsigned idle_gap(int unsigned longest);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(longest, longest / 2);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: present one beat and hold it until accepted. Valid is left high
  // on return; the next call either drops it for a gap or overwrites the payload
  // in the same step, so valid never takes two assignments in one step.
  // ---------------------------------------------------------------------------
  task automatic send_event(barrier_event_t ev);
    int unsigned gap;
    gap = idle_gap(GAP_LONGEST);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= ev.mode;
    barrier_slot_i <= ev.slot;
    member_i       <= ev.member;
    outcome_i      <= ev.outcome;
    expected_in_i  <= ev.members;
    arrival_rule_i <= ev.arr_rule;
    failure_rule_i <= ev.flr_rule;
    timeout_rule_i <= ev.tmo_rule;
    quorum_fixed_i <= ev.qfix;
    quorum_ratio_i <= ev.ratio;
    do @(posedge clk_i); while (!in_ready_o);
    pending_verdicts.push_back(predict_verdict(ev));
    beats_in++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall at random, compare every result beat with the oldest
  // prediction.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  initial begin : result_monitor
    verdict_t    want;
    int unsigned hold_left;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_verdicts.size() == 0) begin
          $error("result beat with nothing pending: slot %0d reason %0d",
                 slot_out_o, reason_code_o);
          mismatches++;
        end else begin
          want = pending_verdicts.pop_front();
          check_field("slot_out", 32'(want.slot), 32'(slot_out_o));
          check_field("status", 32'(want.status), 32'(status_o));
          check_field("released_set", want.released, released_set_o);
          check_field("dropped_set", want.dropped, dropped_set_o);
          check_field("reason_code", 32'(want.reason), 32'(reason_code_o));
          case (want.status)
            ST_RELEASED: releases_seen++;
            ST_FAILED:   failures_seen++;
            ST_TIMEDOUT: timeouts_seen++;
            default: ;
          endcase
        end
      end
      // Hold ready low for the rest of a stall; otherwise occasionally start one.
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(9) == 0) hold_left = idle_gap(HOLD_LONGEST);
      end
    end
  end

  // Abort if no beat moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $error("no beat moved for %0d cycles, %0d results still pending",
           QUIET_LIMIT, pending_verdicts.size());
    $display("barrier_release_controller_top test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Slots 5 and 15 are unknown straight after reset.
  task automatic test_unknown_slots();
    send_event(member_event(MODE_TIMEOUT, 4'd5, 5'd0, OUT_PASSED));
    send_event(member_event(MODE_ARRIVE, 4'd15, 5'd31, OUT_PASSED));
  endtask

  // All-members rule: release on the last arrival, then answer already released.
  task automatic test_arrival_release();
    logic [3:0] s;
    send_event(create_event(32'h0000_000F, ARR_ALL, FLR_FAIL_BARRIER, TMO_REL_ARRIVED,
                            6'd0, 17'd0));
    s = newest_slot();
    for (int m = 0; m < 4; m++) send_event(member_event(MODE_ARRIVE, s, 5'(m), OUT_PASSED));
    send_event(member_event(MODE_ARRIVE, s, 5'd0, OUT_PASSED));
  endtask

  // Full-ratio quorum with dropped members, and an empty barrier that
  // releases on an early failure under an unlisted failure rule.
  task automatic test_quorum_and_drop();
    logic [3:0] s;
    send_event(create_event('1, ARR_QUORUM, FLR_REMOVE, TMO_REL_QUORUM, 6'd0, 17'd65536));
    s = newest_slot();
    send_event(member_event(MODE_ARRIVE, s, 5'd31, OUT_FAILED));
    send_event(member_event(MODE_FAIL, s, 5'd5, OUT_FAILED));
    send_event(member_event(MODE_TIMEOUT, s, 5'd0, OUT_PASSED));
    send_event(create_event('0, ARR_DROP_FAIL, FLR_UNLISTED, TMO_UNLISTED_HI, 6'd63,
                            17'd131071));
    send_event(member_event(MODE_FAIL, newest_slot(), 5'd0, OUT_OTHER));
  endtask

  // Fail-barrier rule: a failed arrival fails the barrier, an early failure
  // reports both sets empty.
  task automatic test_failure_rules();
    logic [3:0] s;
    send_event(create_event(32'hFFFF_0000, ARR_COUNT_FAIL, FLR_FAIL_BARRIER, TMO_EXPIRE,
                            6'd32, 17'd1));
    s = newest_slot();
    send_event(member_event(MODE_ARRIVE, s, 5'd16, OUT_OTHER_HI));
    send_event(member_event(MODE_FAIL, s, 5'd20, OUT_FAILED));
  endtask

  // Timeout rules: time out, keep evaluating afterwards, release arrived,
  // and an unlisted rule that times out.
  task automatic test_timeout_rules();
    logic [3:0] s;
    s = newest_slot();
    send_event(member_event(MODE_TIMEOUT, s, 5'd0, OUT_PASSED));
    send_event(member_event(MODE_ARRIVE, s, 5'd17, OUT_PASSED));
    send_event(create_event(32'hAAAA_AAAA, ARR_QUORUM, FLR_CONTINUE, TMO_REL_ARRIVED,
                            6'd0, 17'd0));
    send_event(member_event(MODE_TIMEOUT, newest_slot(), 5'd1, OUT_PASSED));
    send_event(create_event(32'h5555_5555, ARR_QUORUM, FLR_CONTINUE, TMO_UNLISTED_LO,
                            6'd2, 17'h08000));
    s = newest_slot();
    send_event(member_event(MODE_ARRIVE, s, 5'd0, OUT_PASSED));
    send_event(member_event(MODE_ARRIVE, s, 5'd2, OUT_FAILED));
    send_event(member_event(MODE_TIMEOUT, s, 5'd0, OUT_PASSED));
  endtask

  // Barrier lifetimes with random policies, plus a share of arbitrary beats.
  task automatic test_random_traffic(int unsigned count);
    int unsigned r;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 100 == 0) calm = ($urandom_range(3) == 0);
      r = $urandom_range(99);
      if (creates_seen == 0 || r < 9) send_event(random_create_event());
      else if (r < 90) send_event(random_member_event());
      else send_event(scatter_event());
    end
    calm = 1'b0;
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unknown_slots();
    test_arrival_release();
    test_quorum_and_drop();
    test_failure_rules();
    test_timeout_rules();
    test_random_traffic(RANDOM_BEATS);

    // Drop valid after the last accept, drain, then watch for strays.
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d beats, checked %0d results: %0d released, %0d failed, %0d timed out.",
             beats_in, results_seen, releases_seen, failures_seen, timeouts_seen);
    $display("Created %0d barriers over %0d slots; %0d field mismatches.",
             creates_seen, SLOTS, mismatches);
    if (mismatches == 0) begin
      $display("barrier_release_controller_top test passed");
    end else begin
      $display("barrier_release_controller_top test failed");
    end
    $finish;
  end

endmodule
